@@ sv/rne_pkg.sv @@
// ----------------------------------------------------------------------------
// rne_pkg: shared types, constants and letter tables
// Widths, digit types and the ASCII letter map of the Roman numeral encoder.
// ----------------------------------------------------------------------------
package rne_pkg;

  localparam int VALUE_W     = 12;
  localparam int SYMBOL_W    = 7;
  localparam int DIGIT_W     = 4;
  localparam int NUM_PLACES  = 4;
  localparam int PLACE_W     = 2;
  localparam int POS_W       = 2;
  localparam int LEN_W       = 3;
  localparam int CONV_STEPS  = VALUE_W;
  localparam int QUEUE_DEPTH = 2;

  // Place indexes: thousands first on the way out
  localparam logic [PLACE_W-1:0] PLACE_ONES      = 2'd0;
  localparam logic [PLACE_W-1:0] PLACE_TENS      = 2'd1;
  localparam logic [PLACE_W-1:0] PLACE_HUNDREDS  = 2'd2;
  localparam logic [PLACE_W-1:0] PLACE_THOUSANDS = 2'd3;

  // ASCII letters
  localparam logic [SYMBOL_W-1:0] CHAR_I = 7'h49;
  localparam logic [SYMBOL_W-1:0] CHAR_V = 7'h56;
  localparam logic [SYMBOL_W-1:0] CHAR_X = 7'h58;
  localparam logic [SYMBOL_W-1:0] CHAR_L = 7'h4C;
  localparam logic [SYMBOL_W-1:0] CHAR_C = 7'h43;
  localparam logic [SYMBOL_W-1:0] CHAR_D = 7'h44;
  localparam logic [SYMBOL_W-1:0] CHAR_M = 7'h4D;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef digit_t [NUM_PLACES-1:0] digits_t;

  // Front to queue transaction
  typedef struct packed {
    logic    valid;
    digits_t digits;
  } push_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Which letter of a place a character uses
  typedef enum logic [1:0] {
    KIND_ONE,
    KIND_FIVE,
    KIND_TEN
  } kind_e;

  // Number of letters for a decimal digit below the thousands
  function automatic logic [LEN_W-1:0] digit_len(digit_t d);
    logic [LEN_W-1:0] len;
    case (d)
      4'd1:    len = 3'd1;
      4'd2:    len = 3'd2;
      4'd3:    len = 3'd3;
      4'd4:    len = 3'd2;
      4'd5:    len = 3'd1;
      4'd6:    len = 3'd2;
      4'd7:    len = 3'd3;
      4'd8:    len = 3'd4;
      4'd9:    len = 3'd2;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  // Letter kind at a position within a digit's pattern
  function automatic kind_e digit_kind(digit_t d, logic [POS_W-1:0] pos);
    kind_e k;
    case (d)
      4'd4:    k = (pos == 2'd0) ? KIND_ONE : KIND_FIVE;
      4'd5:    k = KIND_FIVE;
      4'd6,
      4'd7,
      4'd8:    k = (pos == 2'd0) ? KIND_FIVE : KIND_ONE;
      4'd9:    k = (pos == 2'd0) ? KIND_ONE : KIND_TEN;
      default: k = KIND_ONE;
    endcase
    return k;
  endfunction

  // ASCII letter for a place and a letter kind
  function automatic logic [SYMBOL_W-1:0] place_letter(logic [PLACE_W-1:0] place,
                                                       kind_e k);
    logic [SYMBOL_W-1:0] s;
    case (place)
      PLACE_THOUSANDS: s = CHAR_M;
      PLACE_HUNDREDS:  s = (k == KIND_ONE) ? CHAR_C : (k == KIND_FIVE) ? CHAR_D : CHAR_M;
      PLACE_TENS:      s = (k == KIND_ONE) ? CHAR_X : (k == KIND_FIVE) ? CHAR_L : CHAR_C;
      default:         s = (k == KIND_ONE) ? CHAR_I : (k == KIND_FIVE) ? CHAR_V : CHAR_X;
    endcase
    return s;
  endfunction

endpackage

@@ sv/rne_front.sv @@
// ----------------------------------------------------------------------------
// rne_front: input stage and binary to decimal conversion
// Accepts a value, drops zero, and splits the rest into four decimal digits
// with a shift-and-add-three loop, one input bit per cycle.
// ----------------------------------------------------------------------------
module rne_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [rne_pkg::VALUE_W-1:0]    value_i,
  output rne_pkg::push_t                 push_o,
  input  rne_pkg::q_stat_t               q_stat_i
);

  localparam int CNT_W  = $clog2(rne_pkg::CONV_STEPS);
  localparam int BCD_W  = rne_pkg::DIGIT_W * rne_pkg::NUM_PLACES;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_PUSH
  } state_e;

  state_e                       state_q;
  logic [CNT_W-1:0]             cnt_q;
  logic [rne_pkg::VALUE_W-1:0]  sh_q;
  logic [BCD_W-1:0]             bcd_q;
  logic [BCD_W-1:0]             bcd_adj;

  // Add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < rne_pkg::NUM_PLACES; i++) begin
      bcd_adj[i*rne_pkg::DIGIT_W +: rne_pkg::DIGIT_W] =
        (bcd_q[i*rne_pkg::DIGIT_W +: rne_pkg::DIGIT_W] >= rne_pkg::DIGIT_W'(5)) ?
        bcd_q[i*rne_pkg::DIGIT_W +: rne_pkg::DIGIT_W] + rne_pkg::DIGIT_W'(3) :
        bcd_q[i*rne_pkg::DIGIT_W +: rne_pkg::DIGIT_W];
    end
  end

  // Sequence accept, conversion and hand-off to the queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      sh_q    <= '0;
      bcd_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i && (value_i != '0)) begin
            sh_q    <= value_i;
            bcd_q   <= '0;
            cnt_q   <= '0;
            state_q <= ST_CONV;
          end
        end
        ST_CONV: begin
          bcd_q <= {bcd_adj[BCD_W-2:0], sh_q[rne_pkg::VALUE_W-1]};
          sh_q  <= {sh_q[rne_pkg::VALUE_W-2:0], 1'b0};
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(rne_pkg::CONV_STEPS - 1)) begin
            state_q <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!q_stat_i.full) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign push_o.valid  = (state_q == ST_PUSH);
  assign push_o.digits = rne_pkg::digits_t'(bcd_q);

endmodule

@@ sv/rne_queue.sv @@
// ----------------------------------------------------------------------------
// rne_queue: digit queue between front and back
// Small first-in first-out buffer of converted digit sets.
// ----------------------------------------------------------------------------
module rne_queue #(
  parameter int Depth = rne_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rne_pkg::push_t    push_i,
  input  logic              pop_i,
  output rne_pkg::digits_t  data_o,
  output rne_pkg::q_stat_t  q_stat_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  rne_pkg::digits_t  mem_q [Depth];
  logic [AW-1:0]     wr_ptr_q;
  logic [AW-1:0]     rd_ptr_q;
  logic [CW-1:0]     count_q;
  logic              do_push;
  logic              do_pop;

  assign q_stat_o.full  = (count_q == CW'(Depth));
  assign q_stat_o.empty = (count_q == '0);
  assign do_push        = push_i.valid && !q_stat_o.full;
  assign do_pop         = pop_i && !q_stat_o.empty;
  assign data_o         = mem_q[rd_ptr_q];

  // Write the entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.digits;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + CW'(1);
        2'b01:   count_q <= count_q - CW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

@@ sv/rne_back.sv @@
// ----------------------------------------------------------------------------
// rne_back: letter sequencer and output register
// Walks the digit set from thousands to ones and emits one letter per cycle
// while the output is not stalled, flagging the final letter of the numeral.
// ----------------------------------------------------------------------------
module rne_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rne_pkg::digits_t               data_i,
  input  rne_pkg::q_stat_t               q_stat_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [rne_pkg::SYMBOL_W-1:0]   symbol_o,
  output logic                           last_o
);

  logic                           active_q;
  rne_pkg::digits_t               digits_q;
  logic [rne_pkg::PLACE_W-1:0]    place_q;
  logic [rne_pkg::POS_W-1:0]      pos_q;
  logic                           out_valid_q;
  logic [rne_pkg::SYMBOL_W-1:0]   symbol_q;
  logic                           last_q;

  logic                           adv;
  logic [rne_pkg::PLACE_W-1:0]    top_place;
  logic [rne_pkg::PLACE_W-1:0]    next_place;
  logic                           has_next;
  rne_pkg::digit_t                cur_digit;
  logic [rne_pkg::LEN_W-1:0]      cur_len;
  logic                           more_in_digit;
  logic [rne_pkg::SYMBOL_W-1:0]   cur_symbol;

  // Output register frees when empty or taken
  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = !active_q && !q_stat_i.empty;

  // Highest nonzero place of a new digit set
  always_comb begin
    top_place = rne_pkg::PLACE_ONES;
    for (int i = 0; i < rne_pkg::NUM_PLACES; i++) begin
      if (data_i[i] != '0) begin
        top_place = rne_pkg::PLACE_W'(i);
      end
    end
  end

  // Next nonzero place below the current one
  always_comb begin
    next_place = rne_pkg::PLACE_ONES;
    has_next   = 1'b0;
    for (int i = 0; i < rne_pkg::NUM_PLACES; i++) begin
      if ((rne_pkg::PLACE_W'(i) < place_q) && (digits_q[i] != '0)) begin
        next_place = rne_pkg::PLACE_W'(i);
        has_next   = 1'b1;
      end
    end
  end

  // Current letter and pattern length
  always_comb begin
    cur_digit     = digits_q[place_q];
    cur_len       = (place_q == rne_pkg::PLACE_THOUSANDS) ?
                    cur_digit[rne_pkg::LEN_W-1:0] : rne_pkg::digit_len(cur_digit);
    more_in_digit = ({1'b0, pos_q} + rne_pkg::LEN_W'(1)) < cur_len;
    cur_symbol    = rne_pkg::place_letter(place_q, rne_pkg::digit_kind(cur_digit, pos_q));
  end

  // Load a digit set, step through its letters, hold the output while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      digits_q    <= '0;
      place_q     <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      symbol_q    <= '0;
      last_q      <= 1'b0;
    end else begin
      if (pop_o) begin
        active_q <= 1'b1;
        digits_q <= data_i;
        place_q  <= top_place;
        pos_q    <= '0;
      end
      if (adv) begin
        out_valid_q <= active_q;
        if (active_q) begin
          symbol_q <= cur_symbol;
          if (more_in_digit) begin
            pos_q  <= pos_q + rne_pkg::POS_W'(1);
            last_q <= 1'b0;
          end else if (has_next) begin
            place_q <= next_place;
            pos_q   <= '0;
            last_q  <= 1'b0;
          end else begin
            active_q <= 1'b0;
            last_q   <= 1'b1;
          end
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign symbol_o    = symbol_q;
  assign last_o      = last_q;

endmodule

@@ sv/roman_numeral_encoder.sv @@
// A nonzero value passes the conversion loop, the queue hand-off, the load into
// the back and the output register. A zero value is accepted and emits nothing.
// The back emits one letter per cycle while the output is not stalled and takes
// a new digit set only after the last letter of the one before. The front takes
// no new value until its bit-per-cycle loop ends and its digits are queued.
// Reset (rst_ni, asynchronous, active low) empties the queue and the output.
// ----------------------------------------------------------------------------
// roman_numeral_encoder: integer to Roman numeral letters
// Front converts a value to decimal digits, a queue decouples it from the
// back, which emits the numeral as ASCII letters with a last flag.
// ----------------------------------------------------------------------------
module roman_numeral_encoder #(
  parameter int QueueDepth = rne_pkg::QUEUE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [rne_pkg::VALUE_W-1:0]    value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [rne_pkg::SYMBOL_W-1:0]   symbol_o,
  output logic                           last_o
);

  rne_pkg::push_t    push;
  rne_pkg::q_stat_t  q_stat;
  rne_pkg::digits_t  q_data;
  logic              pop;

  // Accept and convert
  rne_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .value_i    (value_i),
    .push_o     (push),
    .q_stat_i   (q_stat)
  );

  // Buffer digit sets
  rne_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .pop_i    (pop),
    .data_o   (q_data),
    .q_stat_o (q_stat)
  );

  // Emit letters
  rne_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .data_i      (q_data),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .symbol_o    (symbol_o),
    .last_o      (last_o)
  );

endmodule

@@ sv/rne_checker.sv @@
// ----------------------------------------------------------------------------
// rne_checker: port-level checks for the Roman numeral encoder
// Watches the top-level ports over time; attached by bind.
// ----------------------------------------------------------------------------
module rne_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_o,
  input  logic [rne_pkg::VALUE_W-1:0]    value_i,
  input  logic                           out_valid_o,
  input  logic                           out_stall_i,
  input  logic [rne_pkg::SYMBOL_W-1:0]   symbol_o,
  input  logic                           last_o
);

  logic in_acc;
  logic out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Hold a stalled output transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(symbol_o) && $stable(last_o)))
    else $error("stalled output transaction changed");

  // Emit only numeral letters
  a_letter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((symbol_o == rne_pkg::CHAR_I) || (symbol_o == rne_pkg::CHAR_V) ||
                     (symbol_o == rne_pkg::CHAR_X) || (symbol_o == rne_pkg::CHAR_L) ||
                     (symbol_o == rne_pkg::CHAR_C) || (symbol_o == rne_pkg::CHAR_D) ||
                     (symbol_o == rne_pkg::CHAR_M)))
    else $error("output letter outside the numeral alphabet");

  // Follow a non-final letter with the next one at once
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !last_o) |=> out_valid_o)
    else $error("gap inside a numeral");

  // Busy converting after a nonzero value
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (value_i != '0)) |=> in_stall_o)
    else $error("input not stalled during conversion");

endmodule

bind roman_numeral_encoder rne_checker u_rne_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .value_i     (value_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .symbol_o    (symbol_o),
  .last_o      (last_o)
);

@@ sim/roman_numeral_encoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roman_numeral_encoder_tb: self-checking bench for the Roman numeral encoder
// Sends whole numbers, predicts the letter stream of each numeral and checks
// every letter and its last flag under several idle and stall patterns.
// ----------------------------------------------------------------------------
module roman_numeral_encoder_tb;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 7;
  localparam int ROMAN_STEPS  = 13;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_LIMIT  = 100000;
  localparam int END_CYCLES   = 40;
  localparam int RANDOM_ITEMS = 100;

  // One expected letter of a numeral
  typedef struct {
    logic [rne_pkg::SYMBOL_W-1:0] symbol;
    logic                         last;
  } letter_t;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_stall_o;
  logic [rne_pkg::VALUE_W-1:0]  value_i     = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [rne_pkg::SYMBOL_W-1:0] symbol_o;
  logic                         last_o;

  letter_t     expected_letters[$];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned fail_count     = 0;
  logic        hold_off       = 1'b0;
  event        start_hold;

  roman_numeral_encoder DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .symbol_o    (symbol_o),
    .last_o      (last_o)
  );

  // Run the clock
  initial begin
    forever begin
      #(CLK_PERIOD / 2) clk_i = ~clk_i;
    end
  end

  // Abort a hung run
  initial begin
    #(10_000_000);
    $display("simulation failed");
    $finish;
  end

  // Greedy conversion: append the letters of v, last flag on the final one
  function automatic void predict_numeral(input logic [rne_pkg::VALUE_W-1:0] v);
    int unsigned                  rest;
    int unsigned                  weight;
    logic [rne_pkg::SYMBOL_W-1:0] first;
    logic [rne_pkg::SYMBOL_W-1:0] second;
    logic [rne_pkg::SYMBOL_W-1:0] letters[$];
    letter_t                      entry;
    rest = v;
    for (int k = 0; k < ROMAN_STEPS; k++) begin
      second = '0;
      case (k)
        0: begin
          weight = 1000; first = rne_pkg::CHAR_M;
        end
        1: begin
          weight = 900; first = rne_pkg::CHAR_C; second = rne_pkg::CHAR_M;
        end
        2: begin
          weight = 500; first = rne_pkg::CHAR_D;
        end
        3: begin
          weight = 400; first = rne_pkg::CHAR_C; second = rne_pkg::CHAR_D;
        end
        4: begin
          weight = 100; first = rne_pkg::CHAR_C;
        end
        5: begin
          weight = 90; first = rne_pkg::CHAR_X; second = rne_pkg::CHAR_C;
        end
        6: begin
          weight = 50; first = rne_pkg::CHAR_L;
        end
        7: begin
          weight = 40; first = rne_pkg::CHAR_X; second = rne_pkg::CHAR_L;
        end
        8: begin
          weight = 10; first = rne_pkg::CHAR_X;
        end
        9: begin
          weight = 9; first = rne_pkg::CHAR_I; second = rne_pkg::CHAR_X;
        end
        10: begin
          weight = 5; first = rne_pkg::CHAR_V;
        end
        11: begin
          weight = 4; first = rne_pkg::CHAR_I; second = rne_pkg::CHAR_V;
        end
        default: begin
          weight = 1; first = rne_pkg::CHAR_I;
        end
      endcase
      while (rest >= weight) begin
        letters.push_back(first);
        if (second != '0) letters.push_back(second);
        rest = rest - weight;
      end
    end
    for (int i = 0; i < letters.size(); i++) begin
      entry.symbol = letters[i];
      entry.last   = (i == letters.size() - 1);
      expected_letters.push_back(entry);
    end
  endfunction

  // Offer one value, idle first at random, and predict on acceptance
  task automatic send_value(input logic [rne_pkg::VALUE_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      value_i    <= rne_pkg::VALUE_W'($urandom);
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
    predict_numeral(v);
  endtask

  // Mostly legal range, with zeros, small values and the top of the field
  function automatic logic [rne_pkg::VALUE_W-1:0] random_value();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5) return '0;
    else if (pick < 15) return rne_pkg::VALUE_W'($urandom_range(4095, 4000));
    else if (pick < 30) return rne_pkg::VALUE_W'($urandom_range(49, 1));
    else return rne_pkg::VALUE_W'($urandom_range(3999, 0));
  endfunction

  task automatic send_random_values(input int n);
    for (int i = 0; i < n; i++) send_value(random_value());
  endtask

  // Drive receiver stall: long hold-off or random stalls
  always @(posedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // Count out a long receiver hold-off on request
  initial begin
    forever begin
      @(start_hold);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_off <= 1'b0;
    end
  end

  // Check each accepted letter against the oldest prediction
  always @(posedge clk_i) begin : check_letters
    letter_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_letters.size() == 0) begin
        $error("unexpected letter 0x%0h last %0b", symbol_o, last_o);
        fail_count++;
      end else begin
        want = expected_letters.pop_front();
        if (symbol_o !== want.symbol) begin
          $error("symbol: expected 0x%0h, actual 0x%0h", want.symbol, symbol_o);
          fail_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, last_o);
          fail_count++;
        end
      end
    end
  end

  // Zero, every pair, every single letter, longest numerals, above 3999
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_value(12'd0);
    send_value(12'd1);
    send_value(12'd4);
    send_value(12'd5);
    send_value(12'd9);
    send_value(12'd10);
    send_value(12'd40);
    send_value(12'd50);
    send_value(12'd90);
    send_value(12'd100);
    send_value(12'd400);
    send_value(12'd500);
    send_value(12'd900);
    send_value(12'd1000);
    send_value(12'd0);
    send_value(12'd0);
    send_value(12'd1994);
    send_value(12'd3888);
    send_value(12'd3999);
    send_value(12'd4000);
    send_value(12'd4088);
    send_value(12'd4095);
    send_value(12'd2730);
    send_value(12'd1365);
  endtask

  task automatic test_no_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_random_values(RANDOM_ITEMS);
  endtask

  task automatic test_sender_idle();
    send_idle_pct  = 84;
    recv_stall_pct = 0;
    send_random_values(RANDOM_ITEMS);
  endtask

  task automatic test_receiver_stall();
    send_idle_pct  = 0;
    recv_stall_pct = 84;
    send_random_values(RANDOM_ITEMS);
  endtask

  task automatic test_both_idle();
    send_idle_pct  = 16;
    recv_stall_pct = 16;
    send_random_values(RANDOM_ITEMS);
  endtask

  // Hold the receiver off while long numerals keep coming, to fill the block
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    -> start_hold;
    for (int i = 0; i < 10; i++) send_value((i % 2 == 0) ? 12'd3888 : random_value());
    send_random_values(10);
  endtask

  // Reset, run each test in turn, drain and report
  initial begin : main_seq
    int drain_cycles;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_backpressure();

    // Drop valid and wait for the last letters
    in_valid_i     <= 1'b0;
    recv_stall_pct = 0;
    drain_cycles   = 0;
    while (expected_letters.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (END_CYCLES) @(posedge clk_i);
    if (expected_letters.size() != 0) begin
      $error("%0d expected letters never arrived", expected_letters.size());
    end

    if (fail_count == 0 && expected_letters.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/rne_pkg.sv
sv/rne_front.sv
sv/rne_queue.sv
sv/rne_back.sv
sv/roman_numeral_encoder.sv
sv/rne_checker.sv
sim/roman_numeral_encoder_tb.sv
